// ----- hdl/rpfr_pkg.sv -----
// Package with widths, codes, the product sequence and the arctangent table.
package rpfr_pkg;

  localparam int POS_W = 32;
  localparam int VEC_W = 18;
  localparam int STAT_W = 16;
  localparam int DELTA_W = 33;
  localparam int ROT_W = 25;
  localparam logic [STAT_W-1:0] GOOD_STATUS_RESET = 16'd1000;
  localparam int CORDIC_STEPS_DEF = 18;

  localparam int OPND_W = 21;
  localparam int PROD_W = 2 * OPND_W;
  localparam int RES_W = 60;
  localparam int HI_SHIFT = 18;
  localparam int NUM_STEPS = 48;
  localparam int SQRT_ITERS = 21;
  localparam int SQ_W = 42;
  localparam int CX_W = 26;
  localparam int CZ_W = 27;
  localparam int ATAN_W = 24;
  localparam logic signed [CZ_W-1:0] DEG90 = 27'sd5898240;
  localparam logic signed [CZ_W-1:0] DEG180 = 27'sd11796480;

  // First-operand sources.
  localparam logic [4:0] A_NR = 5'd0;
  localparam logic [4:0] A_TR = 5'd3;
  localparam logic [4:0] A_CS = 5'd6;
  localparam logic [4:0] A_SA = 5'd9;
  localparam logic [4:0] A_SB = 5'd12;
  // Second-operand sources.
  localparam logic [4:0] B_NC = 5'd0;
  localparam logic [4:0] B_TC = 5'd3;
  localparam logic [4:0] B_TR = 5'd6;
  localparam logic [4:0] B_A = 5'd9;
  localparam logic [4:0] B_B = 5'd12;
  localparam logic [4:0] B_SA = 5'd15;
  localparam logic [4:0] B_SB = 5'd18;
  // Result slots.
  localparam logic [3:0] R_A = 4'd0;
  localparam logic [3:0] R_DN = 4'd3;
  localparam logic [3:0] R_B = 4'd4;
  localparam logic [3:0] R_DT = 4'd7;
  localparam logic [3:0] R_C = 4'd8;
  localparam logic [3:0] R_SX = 4'd11;
  localparam logic [3:0] R_SY = 4'd12;
  localparam logic [3:0] R_SZ = 4'd13;
  localparam logic [3:0] R_QA = 4'd14;
  localparam logic [3:0] R_QB = 4'd15;

  typedef logic [2:0][VEC_W-1:0] vec_t;

  typedef struct packed {
    logic ok;
    logic [2:0][DELTA_W-1:0] delta;
    vec_t nr;
    vec_t nc;
    vec_t tr;
    vec_t tc;
  } item_t;

  typedef struct packed {
    logic [4:0] a_sel;
    logic [4:0] b_sel;
    logic neg;
    logic hi;
    logic first;
    logic last;
    logic [3:0] dest;
  } op_t;

  function automatic op_t mk(logic [4:0] a, logic [4:0] b, logic neg, logic hi,
                             logic first, logic last, logic [3:0] dest);
    op_t o;
    o.a_sel = a;
    o.b_sel = b;
    o.neg = neg;
    o.hi = hi;
    o.first = first;
    o.last = last;
    o.dest = dest;
    return o;
  endfunction

  function automatic op_t prog_op(logic [5:0] s);
    op_t o;
    o = mk(A_NR, B_NC, 1'b0, 1'b0, 1'b0, 1'b0, R_A);
    case (s)
      6'd0:  o = mk(A_NR + 5'd1, B_NC + 5'd2, 1'b0, 1'b0, 1'b1, 1'b0, R_A);
      6'd1:  o = mk(A_NR + 5'd2, B_NC + 5'd1, 1'b1, 1'b0, 1'b0, 1'b1, R_A);
      6'd2:  o = mk(A_NR + 5'd2, B_NC,        1'b0, 1'b0, 1'b1, 1'b0, R_A + 4'd1);
      6'd3:  o = mk(A_NR,        B_NC + 5'd2, 1'b1, 1'b0, 1'b0, 1'b1, R_A + 4'd1);
      6'd4:  o = mk(A_NR,        B_NC + 5'd1, 1'b0, 1'b0, 1'b1, 1'b0, R_A + 4'd2);
      6'd5:  o = mk(A_NR + 5'd1, B_NC,        1'b1, 1'b0, 1'b0, 1'b1, R_A + 4'd2);
      6'd6:  o = mk(A_NR,        B_NC,        1'b0, 1'b0, 1'b1, 1'b0, R_DN);
      6'd7:  o = mk(A_NR + 5'd1, B_NC + 5'd1, 1'b0, 1'b0, 1'b0, 1'b0, R_DN);
      6'd8:  o = mk(A_NR + 5'd2, B_NC + 5'd2, 1'b0, 1'b0, 1'b0, 1'b1, R_DN);
      6'd9:  o = mk(A_TR + 5'd1, B_TC + 5'd2, 1'b0, 1'b0, 1'b1, 1'b0, R_B);
      6'd10: o = mk(A_TR + 5'd2, B_TC + 5'd1, 1'b1, 1'b0, 1'b0, 1'b1, R_B);
      6'd11: o = mk(A_TR + 5'd2, B_TC,        1'b0, 1'b0, 1'b1, 1'b0, R_B + 4'd1);
      6'd12: o = mk(A_TR,        B_TC + 5'd2, 1'b1, 1'b0, 1'b0, 1'b1, R_B + 4'd1);
      6'd13: o = mk(A_TR,        B_TC + 5'd1, 1'b0, 1'b0, 1'b1, 1'b0, R_B + 4'd2);
      6'd14: o = mk(A_TR + 5'd1, B_TC,        1'b1, 1'b0, 1'b0, 1'b1, R_B + 4'd2);
      6'd15: o = mk(A_TR,        B_TC,        1'b0, 1'b0, 1'b1, 1'b0, R_DT);
      6'd16: o = mk(A_TR + 5'd1, B_TC + 5'd1, 1'b0, 1'b0, 1'b0, 1'b0, R_DT);
      6'd17: o = mk(A_TR + 5'd2, B_TC + 5'd2, 1'b0, 1'b0, 1'b0, 1'b1, R_DT);
      6'd18: o = mk(A_NR + 5'd1, B_TR + 5'd2, 1'b0, 1'b0, 1'b1, 1'b0, R_C);
      6'd19: o = mk(A_NR + 5'd2, B_TR + 5'd1, 1'b1, 1'b0, 1'b0, 1'b1, R_C);
      6'd20: o = mk(A_NR + 5'd2, B_TR,        1'b0, 1'b0, 1'b1, 1'b0, R_C + 4'd1);
      6'd21: o = mk(A_NR,        B_TR + 5'd2, 1'b1, 1'b0, 1'b0, 1'b1, R_C + 4'd1);
      6'd22: o = mk(A_NR,        B_TR + 5'd1, 1'b0, 1'b0, 1'b1, 1'b0, R_C + 4'd2);
      6'd23: o = mk(A_NR + 5'd1, B_TR,        1'b1, 1'b0, 1'b0, 1'b1, R_C + 4'd2);
      6'd24: o = mk(A_CS,        B_A,         1'b0, 1'b1, 1'b1, 1'b0, R_SX);
      6'd25: o = mk(A_CS,        B_A,         1'b0, 1'b0, 1'b0, 1'b0, R_SX);
      6'd26: o = mk(A_CS + 5'd1, B_A + 5'd1,  1'b0, 1'b1, 1'b0, 1'b0, R_SX);
      6'd27: o = mk(A_CS + 5'd1, B_A + 5'd1,  1'b0, 1'b0, 1'b0, 1'b0, R_SX);
      6'd28: o = mk(A_CS + 5'd2, B_A + 5'd2,  1'b0, 1'b1, 1'b0, 1'b0, R_SX);
      6'd29: o = mk(A_CS + 5'd2, B_A + 5'd2,  1'b0, 1'b0, 1'b0, 1'b1, R_SX);
      6'd30: o = mk(A_NR,        B_B,         1'b0, 1'b1, 1'b1, 1'b0, R_SY);
      6'd31: o = mk(A_NR,        B_B,         1'b0, 1'b0, 1'b0, 1'b0, R_SY);
      6'd32: o = mk(A_NR + 5'd1, B_B + 5'd1,  1'b0, 1'b1, 1'b0, 1'b0, R_SY);
      6'd33: o = mk(A_NR + 5'd1, B_B + 5'd1,  1'b0, 1'b0, 1'b0, 1'b0, R_SY);
      6'd34: o = mk(A_NR + 5'd2, B_B + 5'd2,  1'b0, 1'b1, 1'b0, 1'b0, R_SY);
      6'd35: o = mk(A_NR + 5'd2, B_B + 5'd2,  1'b0, 1'b0, 1'b0, 1'b1, R_SY);
      6'd36: o = mk(A_TR,        B_A,         1'b0, 1'b1, 1'b1, 1'b0, R_SZ);
      6'd37: o = mk(A_TR,        B_A,         1'b0, 1'b0, 1'b0, 1'b0, R_SZ);
      6'd38: o = mk(A_TR + 5'd1, B_A + 5'd1,  1'b0, 1'b1, 1'b0, 1'b0, R_SZ);
      6'd39: o = mk(A_TR + 5'd1, B_A + 5'd1,  1'b0, 1'b0, 1'b0, 1'b0, R_SZ);
      6'd40: o = mk(A_TR + 5'd2, B_A + 5'd2,  1'b0, 1'b1, 1'b0, 1'b0, R_SZ);
      6'd41: o = mk(A_TR + 5'd2, B_A + 5'd2,  1'b0, 1'b0, 1'b0, 1'b1, R_SZ);
      6'd42: o = mk(A_SA,        B_SA,        1'b0, 1'b0, 1'b1, 1'b0, R_QA);
      6'd43: o = mk(A_SA + 5'd1, B_SA + 5'd1, 1'b0, 1'b0, 1'b0, 1'b0, R_QA);
      6'd44: o = mk(A_SA + 5'd2, B_SA + 5'd2, 1'b0, 1'b0, 1'b0, 1'b1, R_QA);
      6'd45: o = mk(A_SB,        B_SB,        1'b0, 1'b0, 1'b1, 1'b0, R_QB);
      6'd46: o = mk(A_SB + 5'd1, B_SB + 5'd1, 1'b0, 1'b0, 1'b0, 1'b0, R_QB);
      6'd47: o = mk(A_SB + 5'd2, B_SB + 5'd2, 1'b0, 1'b0, 1'b0, 1'b1, R_QB);
      default: o = mk(A_NR, B_NC, 1'b0, 1'b0, 1'b0, 1'b0, R_A);
    endcase
    return o;
  endfunction

  function automatic logic [ATAN_W-1:0] atan_deg(logic [4:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 24'd2949120;
      5'd1:  v = 24'd1740967;
      5'd2:  v = 24'd919879;
      5'd3:  v = 24'd466945;
      5'd4:  v = 24'd234379;
      5'd5:  v = 24'd117304;
      5'd6:  v = 24'd58666;
      5'd7:  v = 24'd29335;
      5'd8:  v = 24'd14668;
      5'd9:  v = 24'd7334;
      5'd10: v = 24'd3667;
      5'd11: v = 24'd1833;
      5'd12: v = 24'd917;
      5'd13: v = 24'd458;
      5'd14: v = 24'd229;
      5'd15: v = 24'd115;
      5'd16: v = 24'd57;
      5'd17: v = 24'd29;
      5'd18: v = 24'd14;
      5'd19: v = 24'd7;
      5'd20: v = 24'd4;
      5'd21: v = 24'd2;
      5'd22: v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/rpfr_ifs.sv -----
// Channel interfaces for samples, results and the configuration write.
interface rpfr_sample_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [17:0] normal_z;
  logic signed [17:0] tangent_x;
  logic signed [17:0] tangent_y;
  logic signed [17:0] tangent_z;
  logic [15:0] status_code;
  modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  tangent_x, tangent_y, tangent_z, status_code, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                tangent_x, tangent_y, tangent_z, status_code, output ready);
endinterface

interface rpfr_result_if;
  logic valid;
  logic ready;
  logic tracking_ok;
  logic signed [32:0] delta_x;
  logic signed [32:0] delta_y;
  logic signed [32:0] delta_z;
  logic signed [24:0] rot_x;
  logic signed [24:0] rot_y;
  logic signed [24:0] rot_z;
  modport source (output valid, tracking_ok, delta_x, delta_y, delta_z, rot_x, rot_y,
                  rot_z, input ready);
  modport sink (input valid, tracking_ok, delta_x, delta_y, delta_z, rot_x, rot_y,
                rot_z, output ready);
endinterface

interface rpfr_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hdl/rpfr_front.sv -----
// Front end: accepts samples, checks status, keeps the reference and forms deltas.
module rpfr_front (
  input  logic clk,
  input  logic rst,
  rpfr_sample_if.sink sample,
  rpfr_cfg_if.sink cfg,
  input  logic q_full,
  output logic push,
  output rpfr_pkg::item_t push_data
);

  logic [rpfr_pkg::STAT_W-1:0] good_status;
  logic have_ref;
  rpfr_pkg::vec_t ref_n;
  rpfr_pkg::vec_t ref_t;
  logic [2:0][rpfr_pkg::POS_W-1:0] ref_p;
  rpfr_pkg::vec_t cur_n;
  rpfr_pkg::vec_t cur_t;
  logic [2:0][rpfr_pkg::POS_W-1:0] cur_p;
  logic [2:0][rpfr_pkg::POS_W-1:0] sel_p;
  logic ok;
  logic accept;

  assign cfg.ready = 1'b1;
  assign sample.ready = !q_full;
  assign accept = sample.valid && sample.ready;
  assign ok = (sample.status_code == good_status);
  assign push = accept;

  assign cur_p = {sample.pos_z, sample.pos_y, sample.pos_x};
  assign cur_n = {sample.normal_z, sample.normal_y, sample.normal_x};
  assign cur_t = {sample.tangent_z, sample.tangent_y, sample.tangent_x};

  always_comb begin
    sel_p = have_ref ? ref_p : cur_p;
    push_data.ok = ok;
    push_data.nr = have_ref ? ref_n : cur_n;
    push_data.tr = have_ref ? ref_t : cur_t;
    push_data.nc = cur_n;
    push_data.tc = cur_t;
    for (int k = 0; k < 3; k++) begin
      push_data.delta[k] = $signed({sel_p[k][rpfr_pkg::POS_W-1], sel_p[k]}) -
                           $signed({cur_p[k][rpfr_pkg::POS_W-1], cur_p[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      good_status <= rpfr_pkg::GOOD_STATUS_RESET;
      have_ref <= 1'b0;
    end else begin
      if (cfg.valid) begin
        good_status <= cfg.data;
      end
      if (accept && ok) begin
        have_ref <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ok && !have_ref) begin
      ref_p <= cur_p;
      ref_n <= cur_n;
      ref_t <= cur_t;
    end
  end

endmodule

// ----- hdl/rpfr_queue.sv -----
// Two-entry queue between the front end and the back end.
module rpfr_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rpfr_pkg::item_t push_data,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output rpfr_pkg::item_t q_data
);

  rpfr_pkg::item_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/rpfr_back.sv -----
// Back end: product sequencer, square root, CORDIC angle unit and result register.
module rpfr_back #(
  parameter int CORDIC_STEPS = rpfr_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  rpfr_pkg::item_t q_data,
  output logic pop,
  rpfr_result_if.source result
);

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_SQL = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_PRE = 4'd5;
  localparam logic [3:0] S_CORD = 4'd6;
  localparam logic [3:0] S_CLAMP = 4'd7;
  localparam logic [3:0] S_FIN = 4'd8;

  logic [3:0] state;
  rpfr_pkg::item_t cur;
  logic [5:0] step;
  rpfr_pkg::op_t op;
  rpfr_pkg::op_t p_op;
  logic p_vld;
  logic signed [rpfr_pkg::PROD_W-1:0] prod;
  logic signed [rpfr_pkg::RES_W-1:0] acc;
  logic signed [rpfr_pkg::RES_W-1:0] acc_next;
  logic signed [rpfr_pkg::RES_W-1:0] ext;
  logic signed [rpfr_pkg::RES_W-1:0] res [16];
  logic signed [rpfr_pkg::OPND_W-1:0] a_cand [15];
  logic signed [rpfr_pkg::OPND_W-1:0] b_cand [21];
  logic signed [rpfr_pkg::OPND_W-1:0] a_val;
  logic signed [rpfr_pkg::OPND_W-1:0] b_val;
  logic ang;
  logic [rpfr_pkg::SQ_W-1:0] sq_v;
  logic [rpfr_pkg::SQ_W-1:0] sq_r;
  logic [rpfr_pkg::SQ_W-1:0] sq_bit;
  logic [rpfr_pkg::SQ_W-1:0] sq_trial;
  logic [4:0] it;
  logic signed [rpfr_pkg::RES_W-1:0] dsel;
  logic signed [rpfr_pkg::CX_W-1:0] x0;
  logic signed [rpfr_pkg::CX_W-1:0] y0;
  logic signed [rpfr_pkg::CX_W-1:0] cx;
  logic signed [rpfr_pkg::CX_W-1:0] cy;
  logic signed [rpfr_pkg::CZ_W-1:0] cz;
  logic signed [rpfr_pkg::CX_W-1:0] xsh;
  logic signed [rpfr_pkg::CX_W-1:0] ysh;
  logic signed [rpfr_pkg::CZ_W-1:0] astep;
  logic [CNT_W-1:0] cnt;
  logic signed [rpfr_pkg::ROT_W-1:0] mag;
  logic signed [rpfr_pkg::ROT_W-1:0] mag_x;
  logic signed [rpfr_pkg::ROT_W-1:0] mag_y;
  logic o_valid;

  assign pop = (state == S_IDLE) && q_valid;
  assign op = rpfr_pkg::prog_op(step);
  assign result.valid = o_valid;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_cand[k] = rpfr_pkg::OPND_W'($signed(cur.nr[k]));
      a_cand[3 + k] = rpfr_pkg::OPND_W'($signed(cur.tr[k]));
      a_cand[6 + k] = $signed(res[8 + k][36:16]);
      a_cand[9 + k] = $signed(res[k][36:16]);
      a_cand[12 + k] = $signed(res[4 + k][36:16]);
      b_cand[k] = rpfr_pkg::OPND_W'($signed(cur.nc[k]));
      b_cand[3 + k] = rpfr_pkg::OPND_W'($signed(cur.tc[k]));
      b_cand[6 + k] = rpfr_pkg::OPND_W'($signed(cur.tr[k]));
      b_cand[9 + k] = op.hi ? $signed(res[k][38:18]) : $signed({3'b000, res[k][17:0]});
      b_cand[12 + k] = op.hi ? $signed(res[4 + k][38:18]) :
                               $signed({3'b000, res[4 + k][17:0]});
      b_cand[15 + k] = $signed(res[k][36:16]);
      b_cand[18 + k] = $signed(res[4 + k][36:16]);
    end
    a_val = a_cand[4'(op.a_sel)];
    b_val = b_cand[op.b_sel];
  end

  always_comb begin
    ext = rpfr_pkg::RES_W'(prod);
    if (p_op.hi) begin
      ext = ext <<< rpfr_pkg::HI_SHIFT;
    end
    acc_next = (p_op.first ? '0 : acc) + (p_op.neg ? -ext : ext);
  end

  always_comb begin
    sq_trial = sq_r + sq_bit;
    dsel = ang ? res[rpfr_pkg::R_DT] : res[rpfr_pkg::R_DN];
    x0 = rpfr_pkg::CX_W'($signed(dsel[36:16]));
    y0 = $signed({5'b00000, sq_r[20:0]});
    xsh = cx >>> cnt;
    ysh = cy >>> cnt;
    astep = $signed({3'b000, rpfr_pkg::atan_deg(5'(cnt))});
    if (cz < 0) begin
      mag = '0;
    end else if (cz > rpfr_pkg::DEG180) begin
      mag = rpfr_pkg::ROT_W'(rpfr_pkg::DEG180);
    end else begin
      mag = cz[rpfr_pkg::ROT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p_vld <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      p_vld <= (state == S_MUL);
      if (state == S_FIN && (!o_valid || result.ready)) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= q_data.ok ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          if (step == 6'(rpfr_pkg::NUM_STEPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_SQL;
        S_SQL: state <= S_SQRT;
        S_SQRT: begin
          if (it == 5'(rpfr_pkg::SQRT_ITERS - 1)) begin
            state <= S_PRE;
          end
        end
        S_PRE: begin
          state <= (x0 == 0 && y0 == 0) ? S_CLAMP : S_CORD;
        end
        S_CORD: begin
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: state <= ang ? S_FIN : S_SQL;
        S_FIN: begin
          if (!o_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (p_vld) begin
      acc <= acc_next;
      if (p_op.last) begin
        res[p_op.dest] <= acc_next;
      end
    end
    case (state)
      S_IDLE: begin
        cur <= q_data;
        step <= '0;
        ang <= 1'b0;
      end
      S_MUL: begin
        p_op <= op;
        prod <= a_val * b_val;
        step <= step + 6'd1;
      end
      S_SQL: begin
        sq_v <= ang ? res[rpfr_pkg::R_QB][rpfr_pkg::SQ_W-1:0] :
                      res[rpfr_pkg::R_QA][rpfr_pkg::SQ_W-1:0];
        sq_r <= '0;
        sq_bit <= rpfr_pkg::SQ_W'(1) << 40;
        it <= '0;
      end
      S_SQRT: begin
        if (sq_v >= sq_trial) begin
          sq_v <= sq_v - sq_trial;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        it <= it + 5'd1;
      end
      S_PRE: begin
        cnt <= '0;
        if (x0 == 0 && y0 == 0) begin
          cz <= '0;
        end else if (x0 < 0) begin
          cx <= y0;
          cy <= -x0;
          cz <= rpfr_pkg::DEG90;
        end else begin
          cx <= x0;
          cy <= y0;
          cz <= '0;
        end
      end
      S_CORD: begin
        if (cy > 0) begin
          cx <= cx + ysh;
          cy <= cy - xsh;
          cz <= cz + astep;
        end else begin
          cx <= cx - ysh;
          cy <= cy + xsh;
          cz <= cz - astep;
        end
        cnt <= cnt + CNT_W'(1);
      end
      S_CLAMP: begin
        if (ang) begin
          mag_y <= mag;
        end else begin
          mag_x <= mag;
        end
        ang <= 1'b1;
      end
      S_FIN: begin
        if (!o_valid || result.ready) begin
          result.tracking_ok <= cur.ok;
          if (cur.ok) begin
            result.delta_x <= $signed(cur.delta[0]);
            result.delta_y <= $signed(cur.delta[1]);
            result.delta_z <= $signed(cur.delta[2]);
            result.rot_x <= res[rpfr_pkg::R_SX][rpfr_pkg::RES_W-1] ? -mag_x : mag_x;
            result.rot_y <= res[rpfr_pkg::R_SY][rpfr_pkg::RES_W-1] ? -mag_y : mag_y;
            result.rot_z <= res[rpfr_pkg::R_SZ][rpfr_pkg::RES_W-1] ? -mag_x : mag_x;
          end else begin
            result.delta_x <= '0;
            result.delta_y <= '0;
            result.delta_z <= '0;
            result.rot_x <= '0;
            result.rot_y <= '0;
            result.rot_z <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/relative_pose_from_reference_top.sv -----
// Top level of the relative pose block: front end, queue and back end.
//
//   Channel   Direction  Carries
//   sample    in         position, normal, tangent and status of one tracker sample
//   cfg       in         good status code
//   result    out        ok flag, position deltas and three rotation angles
//
// A good sample passes the back end through the product sequence, two square roots
// and two CORDIC runs on the one shared unit; a sample with a bad status goes straight
// to the result register. Reset is synchronous and clears the reference. The queue
// holds two samples, so input stalls only when it is full, and the result register
// stalls the back end only while a result is not taken.
module relative_pose_from_reference_top #(
  parameter int CORDIC_STEPS = rpfr_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst,
  rpfr_sample_if.sink sample,
  rpfr_cfg_if.sink cfg,
  rpfr_result_if.source result
);

  logic push;
  logic full;
  logic pop;
  logic q_valid;
  rpfr_pkg::item_t push_data;
  rpfr_pkg::item_t q_data;

  rpfr_front u_front (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .cfg(cfg),
    .q_full(full),
    .push(push),
    .push_data(push_data)
  );

  rpfr_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .q_valid(q_valid),
    .q_data(q_data)
  );

  rpfr_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(q_data),
    .pop(pop),
    .result(result)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the relative pose block with its own pose and angle predictor.
`timescale 1ns / 100ps

module tb;

  localparam int POS_W = rpfr_pkg::POS_W;
  localparam int VEC_W = rpfr_pkg::VEC_W;
  localparam int STAT_W = rpfr_pkg::STAT_W;
  localparam int DELTA_W = rpfr_pkg::DELTA_W;
  localparam int ROT_W = rpfr_pkg::ROT_W;
  localparam logic [STAT_W-1:0] GOOD_STATUS_RESET = rpfr_pkg::GOOD_STATUS_RESET;
  localparam int STEPS = rpfr_pkg::CORDIC_STEPS_DEF;
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 160;
  localparam longint RIGHT_ANGLE = 5898240;
  localparam longint STRAIGHT_ANGLE = 11796480;
  localparam logic [STAT_W-1:0] STATUS_ALL_ONES = 16'hFFFF;

  typedef longint v3_t[3];

  typedef struct {
    logic signed [POS_W-1:0] pos[3];
    logic signed [VEC_W-1:0] nrm[3];
    logic signed [VEC_W-1:0] tan[3];
    logic [STAT_W-1:0] status;
  } sample_t;

  typedef struct {
    logic ok;
    logic signed [DELTA_W-1:0] dx, dy, dz;
    logic signed [ROT_W-1:0] rx, ry, rz;
  } pose_res_t;

  const longint atan_steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  logic clk;
  logic rst;
  rpfr_sample_if sample ();
  rpfr_cfg_if cfg ();
  rpfr_result_if result ();

  relative_pose_from_reference_top i_dut (
    .clk(clk),
    .rst(rst),
    .sample(sample.sink),
    .cfg(cfg.sink),
    .result(result.source)
  );

  logic [STAT_W-1:0] good_code;
  bit have_ref;
  v3_t ref_pos, ref_nrm, ref_tan;
  pose_res_t expected_poses[$];
  int mismatches;
  bit idle_on;
  int hold_len;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void cross3(input v3_t p, input v3_t q, output v3_t r);
    r[0] = p[1] * q[2] - p[2] * q[1];
    r[1] = p[2] * q[0] - p[0] * q[2];
    r[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  function automatic longint dot3(input v3_t p, input v3_t q);
    return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint rotation_deg(input v3_t v, input longint d);
    longint s0, s1, s2, x, y, z, t, xs, ys;
    s0 = v[0] >>> 16;
    s1 = v[1] >>> 16;
    s2 = v[2] >>> 16;
    y = int_sqrt(longint'(s0 * s0 + s1 * s1 + s2 * s2));
    x = d >>> 16;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = RIGHT_ANGLE;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + (i < 24 ? atan_steps[i] : 0);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - (i < 24 ? atan_steps[i] : 0);
      end
    end
    if (z < 0) z = 0;
    if (z > STRAIGHT_ANGLE) z = STRAIGHT_ANGLE;
    return z;
  endfunction

  function automatic pose_res_t predict_pose(input sample_t s);
    pose_res_t r;
    v3_t p, n, t, a, b, c, cs;
    longint mx, my;
    r = '{ok: 1'b0, dx: '0, dy: '0, dz: '0, rx: '0, ry: '0, rz: '0};
    if (s.status != good_code) return r;
    for (int k = 0; k < 3; k++) begin
      p[k] = longint'(s.pos[k]);
      n[k] = longint'(s.nrm[k]);
      t[k] = longint'(s.tan[k]);
    end
    if (!have_ref) begin
      have_ref = 1'b1;
      ref_pos = p;
      ref_nrm = n;
      ref_tan = t;
    end
    cross3(ref_nrm, n, a);
    cross3(ref_tan, t, b);
    cross3(ref_nrm, ref_tan, c);
    for (int k = 0; k < 3; k++) cs[k] = c[k] >>> 16;
    mx = rotation_deg(a, dot3(ref_nrm, n));
    my = rotation_deg(b, dot3(ref_tan, t));
    r.ok = 1'b1;
    r.dx = DELTA_W'(ref_pos[0] - p[0]);
    r.dy = DELTA_W'(ref_pos[1] - p[1]);
    r.dz = DELTA_W'(ref_pos[2] - p[2]);
    r.rx = ROT_W'(dot3(cs, a) < 0 ? -mx : mx);
    r.ry = ROT_W'(dot3(ref_nrm, b) < 0 ? -my : my);
    r.rz = ROT_W'(dot3(ref_tan, a) < 0 ? -mx : mx);
    return r;
  endfunction

  task automatic send_sample(input sample_t s);
    sample.valid <= 1'b1;
    sample.pos_x <= s.pos[0];
    sample.pos_y <= s.pos[1];
    sample.pos_z <= s.pos[2];
    sample.normal_x <= s.nrm[0];
    sample.normal_y <= s.nrm[1];
    sample.normal_z <= s.nrm[2];
    sample.tangent_x <= s.tan[0];
    sample.tangent_y <= s.tan[1];
    sample.tangent_z <= s.tan[2];
    sample.status_code <= s.status;
    do @(posedge clk); while (!sample.ready);
    expected_poses = {expected_poses, predict_pose(s)};
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic settle();
    sample.valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_good_code(input logic [STAT_W-1:0] v);
    settle();
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    good_code = v;
  endtask

  function automatic void unit_vec(output logic signed [VEC_W-1:0] v[3]);
    real a[3], len;
    do begin
      for (int k = 0; k < 3; k++) a[k] = real'(int'($urandom_range(0, 131072)) - 65536);
      len = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    end while (len < 4096.0);
    for (int k = 0; k < 3; k++) v[k] = VEC_W'($rtoi(a[k] / len * 65535.0));
  endfunction

  function automatic void near_vec(input v3_t base, input int spread,
                                   output logic signed [VEC_W-1:0] v[3]);
    for (int k = 0; k < 3; k++)
      v[k] = VEC_W'(base[k] + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++)
      s.pos[k] = ($urandom_range(0, 3) == 0) ?
                 POS_W'(int'($urandom_range(0, 2000000)) - 1000000) : POS_W'($urandom);
    s.status = good_code;
    case (kind)
      0: begin
        for (int k = 0; k < 3; k++) begin
          s.nrm[k] = VEC_W'($urandom);
          s.tan[k] = VEC_W'($urandom);
        end
      end
      1, 2, 3: begin
        unit_vec(s.nrm);
        unit_vec(s.tan);
      end
      4, 5, 6: begin
        near_vec(ref_nrm, 1 << $urandom_range(2, 14), s.nrm);
        near_vec(ref_tan, 1 << $urandom_range(2, 14), s.tan);
      end
      7: begin
        for (int k = 0; k < 3; k++) begin
          s.nrm[k] = $urandom_range(0, 1) ? VEC_W'(-ref_nrm[k]) : '0;
          s.tan[k] = $urandom_range(0, 1) ? VEC_W'(-ref_tan[k]) : VEC_W'(ref_tan[k]);
        end
      end
      default: begin
        unit_vec(s.nrm);
        for (int k = 0; k < 3; k++) s.tan[k] = VEC_W'($urandom);
        s.status = STAT_W'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic test_before_reference();
    sample_t s;
    s = rand_sample();
    s.status = '0;
    send_sample(s);
    s.status = STATUS_ALL_ONES;
    send_sample(s);
    s.status = good_code + 16'd1;
    send_sample(s);
  endtask

  task automatic test_reference_capture();
    sample_t s;
    s.pos = '{32'sd1000000, -32'sd2000000, 32'sd65536};
    unit_vec(s.nrm);
    unit_vec(s.tan);
    s.status = good_code;
    send_sample(s);
    send_sample(s);
  endtask

  task automatic test_field_extremes();
    sample_t s;
    s.status = good_code;
    s.pos = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
    s.nrm = '{18'sh1FFFF, 18'sh20000, 18'sh1FFFF};
    s.tan = '{18'sh20000, 18'sh1FFFF, 18'sh20000};
    send_sample(s);
    s.pos = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
    s.nrm = '{18'sh20000, 18'sh20000, 18'sh20000};
    s.tan = '{18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF};
    send_sample(s);
    s.status = ~good_code;
    send_sample(s);
  endtask

  task automatic test_special_vectors();
    sample_t s;
    s.status = good_code;
    s.pos = '{32'sd0, 32'sd0, 32'sd0};
    s.nrm = '{18'sd0, 18'sd0, 18'sd0};
    s.tan = '{18'sd0, 18'sd0, 18'sd0};
    send_sample(s);
    for (int k = 0; k < 3; k++) begin
      s.nrm[k] = VEC_W'(-ref_nrm[k]);
      s.tan[k] = VEC_W'(-ref_tan[k]);
    end
    send_sample(s);
    for (int k = 0; k < 3; k++) begin
      s.nrm[k] = VEC_W'(ref_nrm[k] >>> 3);
      s.tan[k] = VEC_W'(ref_tan[k] <<< 1);
    end
    send_sample(s);
    near_vec(ref_nrm, 64, s.nrm);
    near_vec(ref_tan, 64, s.tan);
    send_sample(s);
    s.nrm = '{18'sd0, 18'sd0, 18'sd0};
    unit_vec(s.tan);
    send_sample(s);
  endtask

  task automatic test_good_code_settings();
    sample_t s;
    write_good_code('0);
    s = rand_sample();
    s.status = '0;
    send_sample(s);
    s.status = good_code + 16'd1;
    send_sample(s);
    write_good_code(STATUS_ALL_ONES);
    s = rand_sample();
    s.status = STATUS_ALL_ONES;
    send_sample(s);
    s.status = '0;
    send_sample(s);
  endtask

  task automatic test_random_samples(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 75) write_good_code(STAT_W'($urandom));
      send_sample(rand_sample());
    end
  endtask

  task automatic test_backpressure();
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) send_sample(rand_sample());
  endtask

  task automatic test_quiet_tail();
    settle();
    idle_on = 1'b0;
    for (int i = 0; i < 120; i++) send_sample(rand_sample());
    sample.valid <= 1'b0;
  endtask

  initial begin
    hold_len = 0;
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        result.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pose_res_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction at %0t", $realtime);
      end else begin
        e = expected_poses.pop_front();
        if (e.ok !== result.tracking_ok || e.dx !== result.delta_x || e.dy !== result.delta_y ||
            e.dz !== result.delta_z || e.rx !== result.rot_x || e.ry !== result.rot_y ||
            e.rz !== result.rot_z) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: exp ok=%0d d=%0d,%0d,%0d r=%0d,%0d,%0d",
                     $realtime, e.ok, e.dx, e.dy, e.dz, e.rx, e.ry, e.rz);
            $display("  got ok=%0d d=%0d,%0d,%0d r=%0d,%0d,%0d", result.tracking_ok,
                     result.delta_x, result.delta_y, result.delta_z, result.rot_x,
                     result.rot_y, result.rot_z);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    idle_on = 1'b1;
    good_code = GOOD_STATUS_RESET;
    have_ref = 1'b0;
    sample.valid = 1'b0;
    sample.pos_x = '0;
    sample.pos_y = '0;
    sample.pos_z = '0;
    sample.normal_x = '0;
    sample.normal_y = '0;
    sample.normal_z = '0;
    sample.tangent_x = '0;
    sample.tangent_y = '0;
    sample.tangent_z = '0;
    sample.status_code = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_reference();
    test_reference_capture();
    test_field_extremes();
    test_special_vectors();
    test_good_code_settings();
    write_good_code(GOOD_STATUS_RESET);
    test_random_samples(340);
    test_backpressure();
    test_random_samples(340);
    test_quiet_tail();
    settle();
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rpfr_pkg.sv
hdl/rpfr_ifs.sv
hdl/rpfr_front.sv
hdl/rpfr_queue.sv
hdl/rpfr_back.sv
hdl/relative_pose_from_reference_top.sv
tb/tb.sv
